FILE: rtl/core/dhcp_option_parser_unit_macros.svh
// assertion helpers for the dhcp option parser
`ifndef DHCP_OPTION_PARSER_UNIT_MACROS_SVH
`define DHCP_OPTION_PARSER_UNIT_MACROS_SVH

`ifndef SYNTH
`define DOP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("dop assertion failed");
`define DOP_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("dop forbidden condition");
`else
`define DOP_ASSERT(lbl, prop)
`define DOP_NEVER(lbl, expr)
`endif

`endif

FILE: rtl/core/dop_pkg.sv
`default_nettype none

package dop_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic        request_seen;
    logic [7:0]  op_code;
    logic        broadcast_bit;
    logic        multicast_bit;
    logic [31:0] transaction_id;
    logic [31:0] client_address;
    logic [15:0] client_port;
    logic [15:0] client_identifier;
    logic        end_tag_seen;
    logic        options_truncated;
  } result_t;

  // header layout
  localparam logic [7:0] OFF_OP        = 8'd0;
  localparam logic [7:0] OFF_XID_FIRST = 8'd4;
  localparam logic [7:0] OFF_XID_LAST  = 8'd7;
  localparam logic [7:0] OFF_FLAGS     = 8'd10;
  localparam logic [7:0] OFF_CA_FIRST  = 8'd12;
  localparam logic [7:0] OFF_CA_LAST   = 8'd15;
  localparam logic [7:0] OPT_START     = 8'd240;

  localparam int BCAST_BIT = 7;
  localparam int MCAST_BIT = 6;

  // option tags
  localparam logic [7:0] TAG_PAD   = 8'd0;
  localparam logic [7:0] TAG_IDENT = 8'd61;
  localparam logic [7:0] TAG_PORT  = 8'd105;
  localparam logic [7:0] TAG_END   = 8'd255;

  localparam logic [7:0]  REQUEST_OP = 8'h01;
  localparam logic [15:0] RESET_PORT = 16'd67;

endpackage

`default_nettype wire

FILE: rtl/core/dop_walker.sv
`default_nettype none

module dop_walker (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cfg_wr_en,
  input  wire logic [15:0]     cfg_wr_data,
  input  wire logic            in_fire,
  input  wire dop_pkg::in_t    in_item,
  output logic                 res_valid,
  output dop_pkg::result_t     res_data
);

  localparam logic [2:0] PH_HEADER = 3'd0;
  localparam logic [2:0] PH_TAG    = 3'd1;
  localparam logic [2:0] PH_LEN    = 3'd2;
  localparam logic [2:0] PH_DATA   = 3'd3;
  localparam logic [2:0] PH_DONE   = 3'd4;

  logic [15:0] default_port;
  logic [2:0]  phase, phase_next;
  logic [7:0]  byte_offset, byte_offset_next;
  logic [7:0]  option_tag, option_tag_next;
  logic [7:0]  option_remaining, option_remaining_next;
  logic [1:0]  data_count, data_count_next;
  logic [15:0] first_two, first_two_next;
  logic [7:0]  op_store, op_store_next;
  logic [7:0]  flags_store, flags_store_next;
  logic [31:0] xid_store, xid_store_next;
  logic [31:0] caddr_store, caddr_store_next;
  logic [15:0] port_store, port_store_next;
  logic [15:0] ident_store, ident_store_next;
  logic        end_flag, end_flag_next;
  logic        do_apply;
  logic        truncated;
  logic [7:0]  b;

  assign b = in_item.data_byte;

  always_comb begin
    phase_next            = phase;
    byte_offset_next      = byte_offset;
    option_tag_next       = option_tag;
    option_remaining_next = option_remaining;
    data_count_next       = data_count;
    first_two_next        = first_two;
    op_store_next         = op_store;
    flags_store_next      = flags_store;
    xid_store_next        = xid_store;
    caddr_store_next      = caddr_store;
    port_store_next       = port_store;
    ident_store_next      = ident_store;
    end_flag_next         = end_flag;
    do_apply              = 1'b0;
    unique case (phase)
      PH_HEADER: begin
        if (byte_offset == dop_pkg::OFF_OP) begin
          op_store_next = b;
        end
        if (byte_offset >= dop_pkg::OFF_XID_FIRST && byte_offset <= dop_pkg::OFF_XID_LAST) begin
          xid_store_next = {xid_store[23:0], b};
        end
        if (byte_offset == dop_pkg::OFF_FLAGS) begin
          flags_store_next = b;
        end
        if (byte_offset >= dop_pkg::OFF_CA_FIRST && byte_offset <= dop_pkg::OFF_CA_LAST) begin
          caddr_store_next = {caddr_store[23:0], b};
        end
        if (byte_offset < dop_pkg::OPT_START) begin
          byte_offset_next = byte_offset + 8'd1;
        end
        if (byte_offset_next >= dop_pkg::OPT_START) begin
          phase_next = PH_TAG;
        end
      end
      PH_TAG: begin
        if (b == dop_pkg::TAG_END) begin
          end_flag_next = 1'b1;
          phase_next    = PH_DONE;
        end else if (b != dop_pkg::TAG_PAD) begin
          option_tag_next = b;
          phase_next      = PH_LEN;
        end
      end
      PH_LEN: begin
        option_remaining_next = b;
        data_count_next       = 2'd0;
        first_two_next        = 16'd0;
        if (b == 8'd0) begin
          do_apply   = 1'b1;
          phase_next = PH_TAG;
        end else begin
          phase_next = PH_DATA;
        end
      end
      PH_DATA: begin
        if (data_count == 2'd0) begin
          first_two_next  = {b, 8'd0};
          data_count_next = 2'd1;
        end else if (data_count == 2'd1) begin
          first_two_next  = {first_two[15:8], b};
          data_count_next = 2'd2;
        end
        option_remaining_next = option_remaining - 8'd1;
        if (option_remaining_next == 8'd0) begin
          do_apply   = 1'b1;
          phase_next = PH_TAG;
        end
      end
      PH_DONE: begin
      end
      default: begin
        phase_next = phase;
      end
    endcase

    // message ending mid-option still applies what data arrived
    truncated = in_item.last_byte && (phase_next == PH_LEN || phase_next == PH_DATA);
    if (do_apply || (in_item.last_byte && phase_next == PH_DATA)) begin
      if (option_tag_next == dop_pkg::TAG_PORT) begin
        port_store_next = first_two_next;
      end else if (option_tag_next == dop_pkg::TAG_IDENT) begin
        ident_store_next = first_two_next;
      end
    end
  end

  always_comb begin
    res_valid                  = in_fire && in_item.last_byte;
    res_data.request_seen      = (op_store_next == dop_pkg::REQUEST_OP)
                                 && flags_store_next[dop_pkg::MCAST_BIT]
                                 && !flags_store_next[dop_pkg::BCAST_BIT];
    res_data.op_code           = op_store_next;
    res_data.broadcast_bit     = flags_store_next[dop_pkg::BCAST_BIT];
    res_data.multicast_bit     = flags_store_next[dop_pkg::MCAST_BIT];
    res_data.transaction_id    = xid_store_next;
    res_data.client_address    = caddr_store_next;
    res_data.client_port       = port_store_next;
    res_data.client_identifier = ident_store_next;
    res_data.end_tag_seen      = end_flag_next;
    res_data.options_truncated = truncated;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      default_port     <= dop_pkg::RESET_PORT;
      phase            <= PH_HEADER;
      byte_offset      <= 8'd0;
      option_tag       <= 8'd0;
      option_remaining <= 8'd0;
      data_count       <= 2'd0;
      first_two        <= 16'd0;
      op_store         <= 8'd0;
      flags_store      <= 8'd0;
      xid_store        <= 32'd0;
      caddr_store      <= 32'd0;
      port_store       <= dop_pkg::RESET_PORT;
      ident_store      <= 16'd0;
      end_flag         <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        default_port <= cfg_wr_data;
      end
      if (in_fire) begin
        if (in_item.last_byte) begin
          phase            <= PH_HEADER;
          byte_offset      <= 8'd0;
          option_tag       <= 8'd0;
          option_remaining <= 8'd0;
          data_count       <= 2'd0;
          first_two        <= 16'd0;
          op_store         <= 8'd0;
          flags_store      <= 8'd0;
          xid_store        <= 32'd0;
          caddr_store      <= 32'd0;
          port_store       <= default_port;
          ident_store      <= 16'd0;
          end_flag         <= 1'b0;
        end else begin
          phase            <= phase_next;
          byte_offset      <= byte_offset_next;
          option_tag       <= option_tag_next;
          option_remaining <= option_remaining_next;
          data_count       <= data_count_next;
          first_two        <= first_two_next;
          op_store         <= op_store_next;
          flags_store      <= flags_store_next;
          xid_store        <= xid_store_next;
          caddr_store      <= caddr_store_next;
          port_store       <= port_store_next;
          ident_store      <= ident_store_next;
          end_flag         <= end_flag_next;
        end
      end else if (cfg_wr_en && byte_offset == 8'd0 && phase == PH_HEADER) begin
        // no message in progress: takes effect for the next one at once
        port_store <= cfg_wr_data;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/dop_outbuf.sv
`default_nettype none
`include "dhcp_option_parser_unit_macros.svh"

module dop_outbuf (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire dop_pkg::result_t  push_data,
  output logic                   full,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output dop_pkg::result_t       out_data
);

  logic             skid_valid;
  dop_pkg::result_t skid_data;
  logic             pop;

  assign pop  = out_valid && out_ready;
  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (!out_valid || pop) begin
        if (skid_valid) begin
          out_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end else begin
          out_valid <= push;
        end
      end else if (push) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || pop) begin
      out_data <= skid_valid ? skid_data : push_data;
    end
    if (out_valid && !pop && push) begin
      skid_data <= push_data;
    end
  end

  `DOP_NEVER(a_skid_without_head, skid_valid && !out_valid)
  `DOP_NEVER(a_push_into_full, push && skid_valid)
  `DOP_ASSERT(a_skid_drains, skid_valid && pop |=> out_valid && !skid_valid)

endmodule

`default_nettype wire

FILE: rtl/core/dhcp_option_parser_unit.sv
// dhcp option parser: takes a message one byte per request on the in channel
// (data_byte plus last_byte on the final byte) and returns one result on the
// out channel per message: op, flags bits, transaction id, client address,
// client port and id from options 105 and 61, end-tag and truncation marks.
// both channels are valid/ready; a request moves when valid and ready are high.
// throughput: one byte per cycle while in_ready is high; the parse state
// updates in the same cycle the byte is taken. the result is registered into
// the output buffer when the last byte is accepted.
// cfg_wr_en/cfg_wr_data load the default client port (reset 67); write it only
// while no message is in flight.
// stall: a two-entry output buffer holds results, so bytes keep flowing while
// one result waits; in_ready drops only when both entries are occupied.
// reset (rst, synchronous) empties the buffer, clears the parse state and sets the client port to 67.
`default_nettype none

module dhcp_option_parser_unit (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_wr_en,
  input  wire logic [15:0]      cfg_wr_data,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire dop_pkg::in_t     in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output dop_pkg::result_t      out_data
);

  logic             in_fire;
  logic             res_valid;
  dop_pkg::result_t res_data;
  logic             buf_full;

  assign in_ready = !buf_full;
  assign in_fire  = in_valid && in_ready;

  dop_walker u_walker (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_fire     (in_fire),
    .in_item     (in_data),
    .res_valid   (res_valid),
    .res_data    (res_data)
  );

  dop_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res_data),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

FILE: tb/dhcp_option_parser_unit_test.sv
`timescale 1ns / 1ps

module dhcp_option_parser_unit_test;

  typedef enum logic [2:0] {PH_HEADER, PH_TAG, PH_LEN, PH_DATA, PH_DONE} parse_phase_e;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_wr_en = 1'b0;
  logic [15:0]      cfg_wr_data = 16'h0000;
  logic             in_valid = 1'b0;
  logic             in_ready;
  dop_pkg::in_t     in_data = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  dop_pkg::result_t out_data;

  dhcp_option_parser_unit i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

  initial forever #5 clk = ~clk;

  dop_pkg::in_t     pending_bytes[$];
  dop_pkg::result_t predicted_results[$];
  logic [7:0]       draft_msg[$];
  int               mismatches = 0;
  int               send_gap = 0;
  int               ready_gap = 0;
  int               hold_left = 0;
  logic             hold_go = 1'b0;
  logic             calm = 1'b0;

  // parser shadow state
  logic [15:0]  dflt_port;
  logic [7:0]   off_cnt;
  parse_phase_e phase;
  logic [7:0]   cur_tag;
  logic [7:0]   opt_left;
  logic [1:0]   data_seen;
  logic [15:0]  lead_data;
  logic [7:0]   op_acc;
  logic [7:0]   flags_acc;
  logic [31:0]  xid_acc;
  logic [31:0]  caddr_acc;
  logic [15:0]  port_acc;
  logic [15:0]  ident_acc;
  logic         end_hit;
  logic         trunc_hit;

  function automatic void clear_parse();
    off_cnt   = '0;
    phase     = PH_HEADER;
    cur_tag   = '0;
    opt_left  = '0;
    data_seen = '0;
    lead_data = '0;
    op_acc    = '0;
    flags_acc = '0;
    xid_acc   = '0;
    caddr_acc = '0;
    port_acc  = dflt_port;
    ident_acc = '0;
    end_hit   = 1'b0;
    trunc_hit = 1'b0;
  endfunction

  function automatic void apply_lead();
    if (cur_tag == dop_pkg::TAG_PORT) begin
      port_acc = lead_data;
    end else if (cur_tag == dop_pkg::TAG_IDENT) begin
      ident_acc = lead_data;
    end
  endfunction

  function automatic bit parse_byte(input dop_pkg::in_t req, output dop_pkg::result_t res);
    logic [7:0] b;
    b = req.data_byte;
    res = '0;
    case (phase)
      PH_HEADER: begin
        if (off_cnt == dop_pkg::OFF_OP) begin
          op_acc = b;
        end else if (off_cnt >= dop_pkg::OFF_XID_FIRST && off_cnt <= dop_pkg::OFF_XID_LAST) begin
          xid_acc = {xid_acc[23:0], b};
        end else if (off_cnt == dop_pkg::OFF_FLAGS) begin
          flags_acc = b;
        end else if (off_cnt >= dop_pkg::OFF_CA_FIRST && off_cnt <= dop_pkg::OFF_CA_LAST) begin
          caddr_acc = {caddr_acc[23:0], b};
        end
        if (off_cnt < dop_pkg::OPT_START) off_cnt++;
        if (off_cnt >= dop_pkg::OPT_START) phase = PH_TAG;
      end
      PH_TAG: begin
        if (b == dop_pkg::TAG_END) begin
          end_hit = 1'b1;
          phase = PH_DONE;
        end else if (b != dop_pkg::TAG_PAD) begin
          cur_tag = b;
          phase = PH_LEN;
        end
      end
      PH_LEN: begin
        opt_left = b;
        data_seen = '0;
        lead_data = '0;
        if (b == 8'd0) begin
          apply_lead();
          phase = PH_TAG;
        end else begin
          phase = PH_DATA;
        end
      end
      PH_DATA: begin
        if (data_seen == 2'd0) begin
          lead_data = {b, 8'h00};
          data_seen = 2'd1;
        end else if (data_seen == 2'd1) begin
          lead_data[7:0] = b;
          data_seen = 2'd2;
        end
        opt_left--;
        if (opt_left == 8'd0) begin
          apply_lead();
          phase = PH_TAG;
        end
      end
      default: ;
    endcase

    if (!req.last_byte) return 1'b0;

    // message ended inside an option: a seen length still applies the option
    if (phase == PH_LEN) begin
      trunc_hit = 1'b1;
    end else if (phase == PH_DATA) begin
      trunc_hit = 1'b1;
      apply_lead();
    end
    res.broadcast_bit     = flags_acc[dop_pkg::BCAST_BIT];
    res.multicast_bit     = flags_acc[dop_pkg::MCAST_BIT];
    res.request_seen      = (op_acc == dop_pkg::REQUEST_OP) && flags_acc[dop_pkg::MCAST_BIT] &&
                            !flags_acc[dop_pkg::BCAST_BIT];
    res.op_code           = op_acc;
    res.transaction_id    = xid_acc;
    res.client_address    = caddr_acc;
    res.client_port       = port_acc;
    res.client_identifier = ident_acc;
    res.end_tag_seen      = end_hit;
    res.options_truncated = trunc_hit;
    clear_parse();
    return 1'b1;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // driver
  always @(posedge clk) begin
    dop_pkg::result_t res;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        if (parse_byte(in_data, res)) predicted_results.push_back(res);
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_bytes.size() != 0 && !calm && $urandom_range(0, 7) == 0) begin
          send_gap <= int'($urandom_range(0, 2));
          in_valid <= 1'b0;
        end else if (pending_bytes.size() != 0) begin
          in_data  <= pending_bytes.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_go) begin
      hold_left <= 120;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // monitor
  always @(posedge clk) begin
    dop_pkg::result_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (predicted_results.size() == 0) begin
          $display("%0t: result with none expected, expected none actual %h", $time,
                   out_data);
          mismatches++;
        end else begin
          want = predicted_results.pop_front();
          check_field("request_seen", 32'(want.request_seen), 32'(out_data.request_seen));
          check_field("op_code", 32'(want.op_code), 32'(out_data.op_code));
          check_field("broadcast_bit", 32'(want.broadcast_bit), 32'(out_data.broadcast_bit));
          check_field("multicast_bit", 32'(want.multicast_bit), 32'(out_data.multicast_bit));
          check_field("transaction_id", want.transaction_id, out_data.transaction_id);
          check_field("client_address", want.client_address, out_data.client_address);
          check_field("client_port", 32'(want.client_port), 32'(out_data.client_port));
          check_field("client_identifier", 32'(want.client_identifier),
                      32'(out_data.client_identifier));
          check_field("end_tag_seen", 32'(want.end_tag_seen), 32'(out_data.end_tag_seen));
          check_field("options_truncated", 32'(want.options_truncated),
                      32'(out_data.options_truncated));
        end
      end
      if (hold_left != 0) begin
        out_ready <= 1'b0;
      end else if (ready_gap > 0) begin
        ready_gap <= ready_gap - 1;
        out_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        ready_gap <= int'($urandom_range(0, 2));
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic add_header(logic [7:0] op, logic [7:0] flags, logic [31:0] xid,
                            logic [31:0] caddr, int upto);
    int i;
    for (i = 0; i < upto; i++) begin
      if (i == int'(dop_pkg::OFF_OP)) begin
        draft_msg.push_back(op);
      end else if (i >= int'(dop_pkg::OFF_XID_FIRST) && i <= int'(dop_pkg::OFF_XID_LAST)) begin
        draft_msg.push_back(xid[31:24]);
        xid = {xid[23:0], 8'h00};
      end else if (i == int'(dop_pkg::OFF_FLAGS)) begin
        draft_msg.push_back(flags);
      end else if (i >= int'(dop_pkg::OFF_CA_FIRST) && i <= int'(dop_pkg::OFF_CA_LAST)) begin
        draft_msg.push_back(caddr[31:24]);
        caddr = {caddr[23:0], 8'h00};
      end else begin
        draft_msg.push_back(8'($urandom));
      end
    end
  endtask

  task automatic add_option(logic [7:0] tag, logic [7:0] len, logic [15:0] lead);
    int i;
    draft_msg.push_back(tag);
    draft_msg.push_back(len);
    for (i = 0; i < int'(len); i++) begin
      draft_msg.push_back(i == 0 ? lead[15:8] : i == 1 ? lead[7:0] : 8'($urandom));
    end
  endtask

  // queue the first keep bytes of the draft message (all of it if keep is out of range)
  task automatic ship_message(int keep);
    int n;
    int i;
    n = (keep <= 0 || keep > draft_msg.size()) ? draft_msg.size() : keep;
    for (i = 0; i < n; i++) begin
      pending_bytes.push_back('{data_byte: draft_msg[i], last_byte: (i == n - 1)});
    end
    draft_msg.delete();
  endtask

  task automatic make_random_message();
    int kind;
    logic [7:0] op;
    logic [7:0] flags;
    logic [7:0] tag;
    logic [7:0] len;
    kind = int'($urandom_range(0, 9));
    if (kind < 2) begin
      repeat ($urandom_range(1, 300)) draft_msg.push_back(8'($urandom));
      ship_message(0);
    end else begin
      case ($urandom_range(0, 2))
        0: op = dop_pkg::REQUEST_OP;
        1: op = 8'h02;
        default: op = 8'($urandom);
      endcase
      case ($urandom_range(0, 4))
        0: flags = 8'h40;
        1: flags = 8'h80;
        2: flags = 8'hc0;
        3: flags = 8'h00;
        default: flags = 8'($urandom);
      endcase
      add_header(op, flags, $urandom, $urandom, int'(dop_pkg::OPT_START));
      repeat ($urandom_range(0, 5)) begin
        case ($urandom_range(0, 4))
          0: tag = dop_pkg::TAG_PAD;
          1: tag = dop_pkg::TAG_PORT;
          2: tag = dop_pkg::TAG_IDENT;
          default: tag = 8'($urandom_range(1, 255));
        endcase
        len = ($urandom_range(0, 15) == 0) ? 8'($urandom_range(5, 255)) :
                                             8'($urandom_range(0, 4));
        if (tag == dop_pkg::TAG_PAD) begin
          draft_msg.push_back(dop_pkg::TAG_PAD);
        end else begin
          add_option(tag, len, 16'($urandom));
        end
      end
      if ($urandom_range(0, 4) != 0) draft_msg.push_back(dop_pkg::TAG_END);
      repeat ($urandom_range(0, 3)) draft_msg.push_back(8'($urandom));
      if (kind == 2) begin
        ship_message(int'($urandom_range(1, 240)));
      end else if (kind == 3) begin
        ship_message(int'($urandom_range(241, draft_msg.size())));
      end else begin
        ship_message(0);
      end
    end
  endtask

  task automatic wait_drain(int extra);
    do @(negedge clk);
    while (pending_bytes.size() != 0 || in_valid || predicted_results.size() != 0);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_default_port(logic [15:0] value);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    dflt_port = value;
    port_acc  = value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  task automatic random_phase(logic [15:0] port, logic quiet);
    write_default_port(port);
    calm <= quiet;
    make_random_message();
    wait_drain(4);
  endtask

  initial begin
    dflt_port = dop_pkg::RESET_PORT;
    clear_parse();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // header-only messages of various lengths
    draft_msg.push_back(8'hff);
    ship_message(0);
    add_header(dop_pkg::REQUEST_OP, 8'h40, 32'hdeadbeef, 32'hc0a80001, 16);
    ship_message(0);
    add_header(dop_pkg::REQUEST_OP, 8'hc0, 32'h01234567, 32'h0, 11);
    ship_message(0);
    add_header(8'h00, 8'h00, 32'h0, 32'h0, 2);
    ship_message(0);
    // message ends on a bare tag
    add_header(8'h00, 8'h00, 32'h0, 32'h0, int'(dop_pkg::OPT_START));
    draft_msg.push_back(dop_pkg::TAG_PORT);
    ship_message(0);
    // pads, zero and one byte of data, repeated and unknown tags, end tag,
    // then bytes that must be ignored
    add_header(dop_pkg::REQUEST_OP, 8'h40, $urandom, $urandom, int'(dop_pkg::OPT_START));
    draft_msg.push_back(dop_pkg::TAG_PAD);
    add_option(dop_pkg::TAG_PORT, 0, 16'h0000);
    add_option(dop_pkg::TAG_IDENT, 1, 16'h5500);
    add_option(dop_pkg::TAG_PORT, 6, 16'hffff);
    add_option(dop_pkg::TAG_PORT, 2, 16'h1234);
    add_option(dop_pkg::TAG_IDENT, 3, 16'habcd);
    add_option(8'd200, 4, 16'h1111);
    add_option(8'd1, 0, 16'h0000);
    draft_msg.push_back(dop_pkg::TAG_PAD);
    draft_msg.push_back(dop_pkg::TAG_END);
    add_option(dop_pkg::TAG_PORT, 2, 16'h5555);
    ship_message(0);
    // cut right after a length byte
    add_header(8'h02, 8'h40, $urandom, $urandom, int'(dop_pkg::OPT_START));
    add_option(dop_pkg::TAG_IDENT, 2, 16'h7788);
    add_option(dop_pkg::TAG_PORT, 4, 16'h9999);
    ship_message(draft_msg.size() - 4);
    // zero-length option on the final byte
    add_header(8'h02, 8'h00, $urandom, $urandom, int'(dop_pkg::OPT_START));
    add_option(8'd254, 0, 16'h0000);
    ship_message(0);
    wait_drain(4);

    // back up the result path while single-byte messages keep coming
    @(posedge clk);
    hold_go <= 1'b1;
    @(posedge clk);
    hold_go <= 1'b0;
    repeat (30) begin
      draft_msg.push_back(8'($urandom));
      ship_message(0);
    end
    wait_drain(4);

    random_phase(16'h0000, 1'b0);
    random_phase(16'($urandom), 1'b0);
    random_phase(16'hffff, 1'b1);
    wait_drain(10);

    if (mismatches == 0) begin
      $display("dhcp_option_parser_unit regression: pass");
    end else begin
      $display("dhcp_option_parser_unit regression: fail");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("dhcp_option_parser_unit regression: fail");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/dop_pkg.sv
rtl/core/dop_walker.sv
rtl/core/dop_outbuf.sv
rtl/core/dhcp_option_parser_unit.sv
tb/dhcp_option_parser_unit_test.sv
